@@ hdl/nma_pkg.sv @@
// nma_pkg: shared types, codes and constants of the neuron multiply-accumulate block
// holds the activation mode codes, register indexes, queue depth and the sigmoid
// table entry function; no dependencies
package nma_pkg;

   localparam int DEF_MAX_INPUTS = 256;
   localparam int DEF_LUT_ENTRIES = 256;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_MODE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIAS_ENABLE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIAS_WEIGHT = 2'd2;

   localparam logic [16:0] ONE_Q16 = 17'd65536;
   localparam logic [16:0] LEAK_Q16 = 17'd655;
   localparam longint unsigned LOG2E_Q16 = 64'd94548;
   localparam int SPAN_Q16 = 8 * 65536;

   typedef enum logic [2:0] {
      MODE_SIGMOID = 3'd0,
      MODE_LINEAR  = 3'd1,
      MODE_RELU    = 3'd2,
      MODE_LEAKY   = 3'd3,
      MODE_TANH    = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_MUL,
      ST_LOOK,
      ST_SHAPE,
      ST_DERIV,
      ST_FIN,
      ST_OUT
   } back_state_type;

   typedef struct packed {
      logic [QUEUE_AW:0] count;
      logic              empty;
   } queue_status_type;

   // 2^(-2^-k) in q30 for k = 1..16
   localparam longint unsigned POW2_FRAC [16] = '{
      64'd759250125,  64'd902905651,  64'd984625594,  64'd1028218693,
      64'd1050733751, 64'd1062175490, 64'd1067942999, 64'd1070838486,
      64'd1072289173, 64'd1073015252, 64'd1073378477, 64'd1073560135,
      64'd1073650976, 64'd1073696399, 64'd1073719111, 64'd1073730468
   };

   // sigmoid at index * step, 1 / (1 + exp(-x)) in q16.16, exp via bitwise 2^-y
   function automatic logic [16:0] sig_entry(input int index, input int step);
      longint unsigned x;
      longint unsigned y;
      longint unsigned n;
      longint unsigned f;
      longint unsigned v;
      longint unsigned e;
      longint unsigned den;
      longint unsigned q;
      longint unsigned num;
      longint unsigned r;
      x = longint'(index) * longint'(step);
      y = (x * LOG2E_Q16) >> 16;
      n = y >> 16;
      f = y & 64'hFFFF;
      v = 64'd1 << 30;
      for (int k = 0; k < 16; k++) begin
         if (f[15-k]) begin
            v = (v * POW2_FRAC[k]) >> 30;
         end
      end
      if (n >= 64'd31) begin
         e = 64'd0;
      end else begin
         e = (v >> n) >> 14;
      end
      den = 64'd65536 + e;
      // rounded quotient by restoring long division, only run when the table is built
      num = (64'd1 << 32) + (den >> 1);
      q = 64'd0;
      r = 64'd0;
      for (int b = 33; b >= 0; b--) begin
         r = (r << 1) | ((num >> b) & 64'd1);
         if (r >= den) begin
            r = r - den;
            q = q | (64'd1 << b);
         end
      end
      return q[16:0];
   endfunction

endpackage

@@ hdl/nma_queue.sv @@
// nma_queue: small word queue between the accumulate front and the activation back
// holds saturated q16.16 sums; depends on nma_pkg
module nma_queue
   import nma_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  logic signed [31:0]  push_data,
   input  logic                pop,
   output logic signed [31:0]  pop_data,
   output queue_status_type    status
);

   logic signed [31:0] mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wptr_ff, wptr_in;
   logic [QUEUE_AW-1:0] rptr_ff, rptr_in;
   logic [QUEUE_AW:0]   count_ff, count_in;

   always_comb begin
      wptr_in = push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in = pop ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= push_data;
      end
   end

   assign pop_data = mem_ff[rptr_ff];
   assign status.count = count_ff;
   assign status.empty = (count_ff == '0);

endmodule

@@ hdl/nma_front.sv @@
// nma_front: accepts words, multiplies and accumulates, and on the last element
// adds bias, rounds and saturates the sum for the queue; depends on nma_pkg
module nma_front
   import nma_pkg::*;
#(
   parameter int MAX_INPUTS = DEF_MAX_INPUTS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic signed [15:0]  req_input_value,
   input  logic signed [15:0]  req_weight_value,
   input  logic                req_last_element,
   input  logic                bias_enable,
   input  logic signed [15:0]  bias_weight,
   input  queue_status_type    q_status,
   output logic                push,
   output logic signed [31:0]  push_data
);

   localparam int CW = $clog2(MAX_INPUTS + 1);
   localparam logic signed [47:0] ACC_MAX = {1'b0, {47{1'b1}}};
   localparam logic signed [47:0] ACC_MIN = {1'b1, {47{1'b0}}};

   logic [CW-1:0] count_ff, count_in;
   logic a_valid_ff, a_valid_in, a_last_ff, a_use_ff;
   logic signed [31:0] a_prod_ff;
   logic signed [47:0] acc_ff, acc_in, acc_sum;
   logic signed [48:0] acc_wide;
   logic b_valid_ff, b_valid_in;
   logic signed [47:0] b_total_ff;
   logic signed [49:0] total;
   logic signed [41:0] rounded;
   logic [QUEUE_AW+1:0] pending;
   logic accept, in_range;

   // lasts still in the pipe reserve a queue slot
   assign pending = (QUEUE_AW+2)'(q_status.count) + (QUEUE_AW+2)'(a_valid_ff & a_last_ff)
                  + (QUEUE_AW+2)'(b_valid_ff);
   assign req_ready = pending < (QUEUE_AW+2)'(QUEUE_DEPTH);
   assign accept = req_valid & req_ready;
   assign in_range = count_ff < CW'(MAX_INPUTS);

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         if (req_last_element) begin
            count_in = '0;
         end else if (in_range) begin
            count_in = count_ff + 1'b1;
         end
      end
      a_valid_in = accept;
   end

   always_comb begin
      acc_wide = 49'(acc_ff) + 49'(a_prod_ff);
      if (acc_wide[48] != acc_wide[47]) begin
         acc_sum = acc_wide[48] ? ACC_MIN : ACC_MAX;
      end else begin
         acc_sum = acc_wide[47:0];
      end
      if (!a_use_ff) begin
         acc_sum = acc_ff;
      end
      acc_in = acc_ff;
      b_valid_in = 1'b0;
      if (a_valid_ff) begin
         acc_in = a_last_ff ? '0 : acc_sum;
         b_valid_in = a_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         acc_ff <= '0;
      end else begin
         count_ff <= count_in;
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_prod_ff <= req_input_value * req_weight_value;
         a_last_ff <= req_last_element;
         a_use_ff <= in_range;
      end
      if (a_valid_ff && a_last_ff) begin
         b_total_ff <= acc_sum;
      end
   end

   // bias times 1.0 in q8.24, then round to q16.16 with floor shift
   always_comb begin
      total = 50'(b_total_ff) + (bias_enable ? 50'(bias_weight) <<< 12 : 50'sd0) + 50'sd128;
      rounded = 42'(total >>> 8);
      if (rounded > 42'sh0_7FFF_FFFF) begin
         push_data = 32'sh7FFF_FFFF;
      end else if (rounded < -42'sh0_8000_0000) begin
         push_data = 32'sh8000_0000;
      end else begin
         push_data = rounded[31:0];
      end
   end

   assign push = b_valid_ff;

endmodule

@@ hdl/nma_back.sv @@
// nma_back: takes sums from the queue and evaluates activation and derivative
// sigmoid and tanh read a constant table built from nma_pkg::sig_entry
module nma_back
   import nma_pkg::*;
#(
   parameter int LUT_ENTRIES = DEF_LUT_ENTRIES
) (
   input  logic                clock,
   input  logic                reset,
   input  queue_status_type    q_status,
   input  logic signed [31:0]  pop_data,
   output logic                pop,
   input  logic [2:0]          activation_mode,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [31:0]  rsp_activation_sum,
   output logic signed [31:0]  rsp_neuron_output,
   output logic [16:0]         rsp_derivative
);

   localparam int STEP = SPAN_Q16 / LUT_ENTRIES;
   localparam int IDXW = $clog2(LUT_ENTRIES);
   localparam longint unsigned SPAN = longint'(LUT_ENTRIES) * longint'(STEP);
   localparam longint unsigned RECIP = ((64'd1 << 38) + longint'(STEP) - 1) / longint'(STEP);
   localparam logic [31:0] RECIP_W = RECIP[31:0];

   logic [16:0] lut [LUT_ENTRIES];

   for (genvar i = 0; i < LUT_ENTRIES; i++) begin : g_lut
      localparam logic [16:0] ENTRY = sig_entry(i, STEP);
      assign lut[i] = ENTRY;
   end

   back_state_type state_ff, state_in;
   mode_type mode;
   logic signed [31:0] sum_ff;
   logic neg_ff, over_ff;
   logic [18:0] mag_ff;
   logic [50:0] prod_ff;
   logic [16:0] p_ff, sig_ff;
   logic signed [18:0] t_ff;
   logic signed [32:0] ma_ff;
   logic signed [17:0] mb_ff;
   logic signed [50:0] prod2_ff;
   logic signed [32:0] scaled;
   logic [32:0] mag;
   logic [16:0] sig;
   logic signed [18:0] t;
   logic signed [34:0] fl;
   logic [IDXW-1:0] idx;

   assign mode = mode_type'(activation_mode);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (!q_status.empty) state_in = ST_SCALE;
         ST_SCALE: state_in = ST_MUL;
         ST_MUL:   state_in = ST_LOOK;
         ST_LOOK:  state_in = ST_SHAPE;
         ST_SHAPE: state_in = ST_DERIV;
         ST_DERIV: state_in = ST_FIN;
         ST_FIN:   state_in = ST_OUT;
         ST_OUT:   if (rsp_ready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      pop = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: pop = !q_status.empty;
         ST_OUT:  rsp_valid = 1'b1;
         default: begin
            pop = 1'b0;
            rsp_valid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      scaled = (mode == MODE_TANH) ? 33'(sum_ff) <<< 1 : 33'(sum_ff);
      mag = scaled[32] ? 33'(-scaled) : 33'(scaled);
      idx = prod_ff[38 +: IDXW];
      sig = neg_ff ? ONE_Q16 - p_ff : p_ff;
      t = $signed({1'b0, sig, 1'b0}) - 19'sd65536;
      fl = 35'(prod2_ff >>> 16);
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: sum_ff <= pop_data;
         ST_SCALE: begin
            neg_ff <= scaled[32];
            over_ff <= 64'(mag) >= SPAN;
            mag_ff <= mag[18:0];
         end
         ST_MUL: prod_ff <= 51'(mag_ff) * 51'(RECIP_W);
         ST_LOOK: p_ff <= over_ff ? ONE_Q16 : lut[idx];
         ST_SHAPE: begin
            sig_ff <= sig;
            t_ff <= t;
            case (mode)
               MODE_SIGMOID: begin
                  ma_ff <= 33'($signed({1'b0, sig}));
                  mb_ff <= 18'($signed({1'b0, ONE_Q16 - sig}));
               end
               MODE_TANH: begin
                  ma_ff <= 33'(t);
                  mb_ff <= 18'(t);
               end
               default: begin
                  ma_ff <= 33'(sum_ff);
                  mb_ff <= 18'($signed({1'b0, LEAK_Q16}));
               end
            endcase
         end
         ST_DERIV: prod2_ff <= 51'(ma_ff) * 51'(mb_ff);
         ST_FIN: begin
            rsp_activation_sum <= sum_ff;
            rsp_neuron_output <= sum_ff;
            rsp_derivative <= ONE_Q16;
            case (mode)
               MODE_SIGMOID: begin
                  rsp_neuron_output <= 32'($signed({1'b0, sig_ff}));
                  rsp_derivative <= fl[16:0];
               end
               MODE_TANH: begin
                  rsp_neuron_output <= 32'(t_ff);
                  rsp_derivative <= ONE_Q16 - fl[16:0];
               end
               MODE_RELU: begin
                  if (sum_ff < 0) begin
                     rsp_neuron_output <= '0;
                     rsp_derivative <= '0;
                  end
               end
               MODE_LEAKY: begin
                  if (sum_ff < 0) begin
                     rsp_neuron_output <= fl[31:0];
                     rsp_derivative <= LEAK_Q16;
                  end
               end
               default: begin
                  rsp_neuron_output <= sum_ff;
                  rsp_derivative <= ONE_Q16;
               end
            endcase
         end
         default: begin
            sum_ff <= sum_ff;
         end
      endcase
   end

endmodule

@@ hdl/neuron_mac_activation.sv @@
// neuron_mac_activation: one neuron, dot product of inputs and weights plus bias,
// followed by a selectable activation; depends on nma_pkg, nma_front, nma_queue, nma_back
//
// req channel: one word per element, input value and weight in signed q4.12,
// last_element closes the vector. Words are taken one per cycle while req_ready is
// high; the front multiplies in one stage and accumulates in the next (48-bit,
// saturating). Elements past MAX_INPUTS in one vector are dropped from the sum.
// rsp channel: one word per vector, the q16.16 sum, the activated output and
// the derivative. The back works on one vector at a time, stepping its sequencer
// through take, scale, reciprocal multiply, table read, shape, derivative multiply,
// final select and output, so vectors the front takes faster than one such pass are
// limited by it. A 4-word queue holds finished sums; when it is full, or would be
// filled by sums still in the front, req_ready drops, so a stalled receiver backs up
// into the front only after 4 vectors queue up.
// csr port: writes take effect at once; write only while the block is idle.
// Reset (synchronous) clears the accumulator, queue and sequencer and sets
// sigmoid mode, bias enabled, bias weight zero.
module neuron_mac_activation
   import nma_pkg::*;
#(
   parameter int MAX_INPUTS = DEF_MAX_INPUTS,
   parameter int LUT_ENTRIES = DEF_LUT_ENTRIES
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic signed [15:0]     req_input_value,
   input  logic signed [15:0]     req_weight_value,
   input  logic                   req_last_element,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic signed [31:0]     rsp_activation_sum,
   output logic signed [31:0]     rsp_neuron_output,
   output logic [16:0]            rsp_derivative,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   logic [2:0] mode_ff;
   logic bias_enable_ff;
   logic signed [15:0] bias_weight_ff;
   queue_status_type q_status;
   logic push, pop;
   logic signed [31:0] push_data, pop_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_SIGMOID;
         bias_enable_ff <= 1'b1;
         bias_weight_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_MODE:        mode_ff <= csr_write_data[2:0];
            CSR_BIAS_ENABLE: bias_enable_ff <= csr_write_data[0];
            CSR_BIAS_WEIGHT: bias_weight_ff <= $signed(csr_write_data);
            default:         mode_ff <= mode_ff;
         endcase
      end
   end

   nma_front #(.MAX_INPUTS(MAX_INPUTS)) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_input_value  (req_input_value),
      .req_weight_value (req_weight_value),
      .req_last_element (req_last_element),
      .bias_enable      (bias_enable_ff),
      .bias_weight      (bias_weight_ff),
      .q_status         (q_status),
      .push             (push),
      .push_data        (push_data)
   );

   nma_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   nma_back #(.LUT_ENTRIES(LUT_ENTRIES)) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_status           (q_status),
      .pop_data           (pop_data),
      .pop                (pop),
      .activation_mode    (mode_ff),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_activation_sum (rsp_activation_sum),
      .rsp_neuron_output  (rsp_neuron_output),
      .rsp_derivative     (rsp_derivative)
   );

endmodule
